@@ design/gsa_pkg.sv @@
// Package for the generational slot allocator: widths, operation and status
// codes, sequencer states and the slot entry type. No dependencies.
`default_nettype none
package gsa_pkg;
  localparam int CAPACITY = 32;
  localparam int SLOT_W   = 5;
  localparam int CNT_W    = 6;
  localparam int GEN_W    = 16;
  localparam int PAY_W    = 32;
  localparam int TIME_W   = 32;

  localparam logic [2:0] MODE_ADD     = 3'd0;
  localparam logic [2:0] MODE_DEACT_H = 3'd1;
  localparam logic [2:0] MODE_DEACT_I = 3'd2;
  localparam logic [2:0] MODE_SWEEP   = 3'd3;
  localparam logic [2:0] MODE_CLEAN   = 3'd4;
  localparam logic [2:0] MODE_QUERY   = 3'd5;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_FULL    = 3'd1;
  localparam logic [2:0] ST_BADH    = 3'd2;
  localparam logic [2:0] ST_STALE   = 3'd3;
  localparam logic [2:0] ST_MISS    = 3'd4;
  localparam logic [2:0] ST_NOTHING = 3'd5;

  typedef enum logic [2:0] {
    S_IDLE, S_ADD, S_LOOK, S_SWEEP, S_CSCAN, S_CSHIFT, S_REBUILD, S_EMIT
  } state_t;

  typedef struct packed {
    logic              act;
    logic [GEN_W-1:0]  gen;
    logic [PAY_W-1:0]  pay;
    logic [TIME_W-1:0] expiry;
  } entry_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
    entry_t            data;
  } entry_wr_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
    logic [SLOT_W-1:0] data;
  } fs_wr_t;
endpackage
`default_nettype wire

@@ design/gsa_alu.sv @@
// Shared compare/subtract unit: expiry against present tick.
// Depends on gsa_pkg.
`default_nettype none
module gsa_alu (
  input  wire logic [gsa_pkg::TIME_W-1:0] expiry,
  input  wire logic [gsa_pkg::TIME_W-1:0] now,
  output logic                            expired,
  output logic [gsa_pkg::TIME_W-1:0]      remain
);
  import gsa_pkg::*;
  logic [TIME_W:0] diff;

  assign diff    = {1'b0, expiry} - {1'b0, now};
  // expired when expiry is not after now
  assign expired = diff[TIME_W] | (diff[TIME_W-1:0] == '0);
  assign remain  = expired ? '0 : diff[TIME_W-1:0];
endmodule
`default_nettype wire

@@ design/gsa_store.sv @@
// Slot table and free stack storage, one read address each.
// Depends on gsa_pkg.
`default_nettype none
module gsa_store (
  input  wire logic                      clk,
  input  wire logic [gsa_pkg::SLOT_W-1:0] rd_addr,
  output gsa_pkg::entry_t                rd_entry,
  input  wire gsa_pkg::entry_wr_t        wr,
  input  wire logic [gsa_pkg::SLOT_W-1:0] fs_rd_addr,
  output logic [gsa_pkg::SLOT_W-1:0]     fs_rd_data,
  input  wire gsa_pkg::fs_wr_t           fs_wr
);
  import gsa_pkg::*;
  entry_t            slots_r [CAPACITY];
  logic [SLOT_W-1:0] stack_r [CAPACITY];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      slots_r[wr.addr] <= wr.data;
    end
    if (fs_wr.en) begin
      stack_r[fs_wr.addr] <= fs_wr.data;
    end
  end

  assign rd_entry   = slots_r[rd_addr];
  assign fs_rd_data = stack_r[fs_rd_addr];
endmodule
`default_nettype wire

@@ design/generational_slot_allocator.sv @@
// Top level of the generational slot allocator: sequencer, counters, output
// register. Depends on gsa_pkg, gsa_store and gsa_alu.
//
//  channel | dir | payload
//  in_     | in  | one operation (mode and operands) per transfer
//  out_    | out | result transfers; tlast marks the final one of an operation
//
// Add, deactivate and query pass through capture, one table access and the
// result. Sweep walks used_count slots, one per cycle while out_tready does
// not stall it; cleanup scans down one slot a cycle, shifts each entry above
// a gap down by one slot and then closes the gap, then rebuilds the free
// stack from the inactive slots. The single table read port and the shared
// subtractor serialise these steps. A stalled out_tready holds the
// sequencer at its next result. rst_n clears counters and control only.
`default_nettype none
module generational_slot_allocator (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // mode[2:0] payload[34:3] expire_time[66:35] current_time[98:67]
  // slot[103:99] handle_generation[119:104] max_removals[125:120]
  input  wire logic [127:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // out_slot[4:0] out_generation[20:5] status[23:21] removed_count[29:24]
  // remaining_time[61:30] out_payload[93:62]
  output logic [95:0]       out_tdata,
  output logic              out_tlast
);
  import gsa_pkg::*;

  state_t state_r, state_nxt;

  logic [2:0]        mode_r;
  logic [PAY_W-1:0]  pay_r;
  logic [TIME_W-1:0] exp_r, now_r;
  logic [SLOT_W-1:0] slot_r;
  logic [GEN_W-1:0]  hgen_r;
  logic [CNT_W-1:0]  maxrem_r;

  logic [CNT_W-1:0]  used_r, used_nxt, fc_r, fc_nxt, idx_r, idx_nxt;
  logic [CNT_W-1:0]  removed_r, removed_nxt;
  logic [SLOT_W-1:0] j_r, j_nxt;
  logic              pend_r, pend_nxt;

  logic [SLOT_W-1:0] res_slot_r, res_slot_nxt;
  logic [GEN_W-1:0]  res_gen_r, res_gen_nxt;
  logic [2:0]        res_st_r, res_st_nxt;
  logic [TIME_W-1:0] res_rem_r, res_rem_nxt;
  logic [PAY_W-1:0]  res_pay_r, res_pay_nxt;

  logic              out_valid_r, out_valid_nxt, out_last_r;
  logic [95:0]       out_data_r;
  logic              out_load, out_load_last;

  logic              accept, out_free;
  logic [SLOT_W-1:0] rd_addr, fs_rd_addr, fs_top;
  entry_t            rd_entry;
  entry_wr_t         wr;
  fs_wr_t            fs_wr;
  logic              expired;
  logic [TIME_W-1:0] remain;
  logic [CNT_W-1:0]  idx_dec, jp1;
  logic [GEN_W-1:0]  gen_inc;
  logic              in_range, hit;

  gsa_store u_store (
    .clk(clk), .rd_addr(rd_addr), .rd_entry(rd_entry), .wr(wr),
    .fs_rd_addr(fs_rd_addr), .fs_rd_data(fs_top), .fs_wr(fs_wr)
  );

  gsa_alu u_alu (
    .expiry(rd_entry.expiry), .now(now_r), .expired(expired), .remain(remain)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid & in_tready;
  assign out_free   = ~out_valid_r | out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  assign idx_dec    = idx_r - CNT_W'(1);
  assign jp1        = {1'b0, j_r} + CNT_W'(1);
  assign fs_rd_addr = SLOT_W'(fc_r - CNT_W'(1));
  assign in_range   = {1'b0, slot_r} < used_r;
  assign hit        = (idx_r < used_r) & rd_entry.act & expired;
  assign gen_inc    = (rd_entry.gen + GEN_W'(1) == '0) ? GEN_W'(1)
                                                       : rd_entry.gen + GEN_W'(1);

  // Table read address
  always_comb begin
    unique case (state_r)
      S_ADD:              rd_addr = fs_top;
      S_SWEEP, S_REBUILD: rd_addr = idx_r[SLOT_W-1:0];
      S_CSCAN:            rd_addr = idx_dec[SLOT_W-1:0];
      S_CSHIFT:           rd_addr = jp1[SLOT_W-1:0];
      default:            rd_addr = slot_r;
    endcase
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_tdata[2:0])
            MODE_ADD:                               state_nxt = S_ADD;
            MODE_DEACT_H, MODE_DEACT_I, MODE_QUERY: state_nxt = S_LOOK;
            MODE_SWEEP:                             state_nxt = S_SWEEP;
            MODE_CLEAN:                             state_nxt = S_CSCAN;
            default:                                state_nxt = S_EMIT;
          endcase
        end
      end
      S_ADD, S_LOOK: state_nxt = S_EMIT;
      S_SWEEP: begin
        if (idx_r >= used_r) state_nxt = S_EMIT;
      end
      S_CSCAN: begin
        if (idx_r == '0 || removed_r >= maxrem_r) begin
          state_nxt = (removed_r != '0) ? S_REBUILD : S_EMIT;
        end else if (!rd_entry.act) begin
          state_nxt = S_CSHIFT;
        end
      end
      S_CSHIFT: begin
        if (jp1 >= used_r) state_nxt = S_CSCAN;
      end
      S_REBUILD: begin
        if (idx_r >= used_r) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and counters
  always_comb begin
    used_nxt      = used_r;
    fc_nxt        = fc_r;
    idx_nxt       = idx_r;
    removed_nxt   = removed_r;
    j_nxt         = j_r;
    pend_nxt      = pend_r;
    res_slot_nxt  = res_slot_r;
    res_gen_nxt   = res_gen_r;
    res_st_nxt    = res_st_r;
    res_rem_nxt   = res_rem_r;
    res_pay_nxt   = res_pay_r;
    out_load      = 1'b0;
    out_load_last = 1'b0;
    wr            = '0;
    fs_wr         = '0;
    wr.addr       = rd_addr;
    wr.data       = rd_entry;
    wr.data.act   = 1'b0;
    fs_wr.addr    = fc_r[SLOT_W-1:0];
    fs_wr.data    = rd_addr;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_slot_nxt = '0;
          res_gen_nxt  = '0;
          res_rem_nxt  = '0;
          res_pay_nxt  = '0;
          res_st_nxt   = (in_tdata[2:0] > MODE_QUERY) ? ST_MISS : ST_OK;
          pend_nxt     = 1'b0;
          removed_nxt  = '0;
          idx_nxt      = (in_tdata[2:0] == MODE_CLEAN) ? used_r : '0;
        end
      end
      S_ADD: begin
        wr.data.pay    = pay_r;
        wr.data.expiry = exp_r;
        wr.data.act    = 1'b1;
        if (fc_r != '0) begin
          wr.en        = 1'b1;
          wr.data.gen  = gen_inc;
          fc_nxt       = fc_r - CNT_W'(1);
          res_slot_nxt = fs_top;
          res_gen_nxt  = gen_inc;
        end else if (used_r < CNT_W'(CAPACITY)) begin
          wr.en        = 1'b1;
          wr.addr      = used_r[SLOT_W-1:0];
          wr.data.gen  = GEN_W'(1);
          used_nxt     = used_r + CNT_W'(1);
          res_slot_nxt = used_r[SLOT_W-1:0];
          res_gen_nxt  = GEN_W'(1);
        end else begin
          res_st_nxt = ST_FULL;
        end
      end
      S_LOOK: begin
        res_slot_nxt = slot_r;
        if (mode_r == MODE_QUERY) begin
          if (in_range && rd_entry.act) begin
            res_rem_nxt = remain;
            res_pay_nxt = rd_entry.pay;
          end else begin
            res_st_nxt = ST_MISS;
          end
        end else if (mode_r == MODE_DEACT_H && hgen_r == '0) begin
          res_st_nxt = ST_BADH;
        end else if (!in_range) begin
          res_st_nxt = ST_MISS;
        end else if (mode_r == MODE_DEACT_H && rd_entry.gen != hgen_r) begin
          res_st_nxt = ST_STALE;
        end else if (!rd_entry.act) begin
          res_st_nxt = ST_MISS;
        end else begin
          // retire: drop the active flag, push the slot on the free stack
          wr.en = 1'b1;
          if (fc_r < CNT_W'(CAPACITY)) begin
            fs_wr.en = 1'b1;
            fc_nxt   = fc_r + CNT_W'(1);
          end
        end
      end
      S_SWEEP: begin
        if (idx_r >= used_r) begin
          if (!pend_r) begin
            res_st_nxt   = ST_NOTHING;
            res_slot_nxt = '0;
          end
        end else if (hit) begin
          if (!pend_r || out_free) begin
            wr.en = 1'b1;
            if (fc_r < CNT_W'(CAPACITY)) begin
              fs_wr.en = 1'b1;
              fc_nxt   = fc_r + CNT_W'(1);
            end
            out_load     = pend_r;
            res_slot_nxt = idx_r[SLOT_W-1:0];
            pend_nxt     = 1'b1;
            idx_nxt      = idx_r + CNT_W'(1);
          end
        end else begin
          idx_nxt = idx_r + CNT_W'(1);
        end
      end
      S_CSCAN: begin
        if (idx_r == '0 || removed_r >= maxrem_r) begin
          res_rem_nxt = '0;
          if (removed_r != '0) begin
            fc_nxt  = '0;
            idx_nxt = '0;
          end
        end else begin
          idx_nxt = idx_dec;
          j_nxt   = idx_dec[SLOT_W-1:0];
        end
      end
      S_CSHIFT: begin
        if (jp1 < used_r) begin
          wr.en       = 1'b1;
          wr.addr     = j_r;
          wr.data.act = rd_entry.act;
          j_nxt       = jp1[SLOT_W-1:0];
        end else begin
          used_nxt    = used_r - CNT_W'(1);
          removed_nxt = removed_r + CNT_W'(1);
        end
      end
      S_REBUILD: begin
        if (idx_r < used_r) begin
          if (!rd_entry.act && fc_r < CNT_W'(CAPACITY)) begin
            fs_wr.en = 1'b1;
            fc_nxt   = fc_r + CNT_W'(1);
          end
          idx_nxt = idx_r + CNT_W'(1);
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_load_last = 1'b1;
        end
      end
      default: ;
    endcase

    out_valid_nxt = out_load | (out_valid_r & ~out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      fc_r        <= '0;
      idx_r       <= '0;
      removed_r   <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      fc_r        <= fc_nxt;
      idx_r       <= idx_nxt;
      removed_r   <= removed_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Operands and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r   <= in_tdata[2:0];
      pay_r    <= in_tdata[34:3];
      exp_r    <= in_tdata[66:35];
      now_r    <= in_tdata[98:67];
      slot_r   <= in_tdata[103:99];
      hgen_r   <= in_tdata[119:104];
      maxrem_r <= in_tdata[125:120];
    end
    j_r        <= j_nxt;
    res_slot_r <= res_slot_nxt;
    res_gen_r  <= res_gen_nxt;
    res_st_r   <= res_st_nxt;
    res_rem_r  <= res_rem_nxt;
    res_pay_r  <= res_pay_nxt;
    if (out_load) begin
      out_data_r <= {2'b00, res_pay_r, res_rem_r,
                     (mode_r == MODE_CLEAN) ? removed_r : CNT_W'(0),
                     res_st_r, res_gen_r, res_slot_r};
      out_last_r <= out_load_last;
    end
  end
endmodule
`default_nettype wire
